// File: design/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   localparam word_type INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int unsigned LEN_POS = 56;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

// File: design/sha256_if.sv
`default_nettype none
interface sha256_req_if;
   logic                 valid;
   logic                 ready;
   sha256_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sha256_rsp_if;
   logic                 valid;
   logic                 ready;
   sha256_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/sha256_fifo.sv
`default_nettype none
// short request queue between the front end and the compression engine
module sha256_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  sha256_pkg::req_type push_data,
   output logic                full,
   input  wire                 pop,
   output sha256_pkg::req_type pop_data,
   output logic                empty
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   sha256_pkg::req_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]   count_ff;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      bump = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push && !full) wr_ptr_ff <= bump(wr_ptr_ff);
         if (pop && !empty) rd_ptr_ff <= bump(rd_ptr_ff);
         count_ff <= count_ff + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
      end
   end
endmodule
`default_nettype wire

// File: design/sha256_front.sv
`default_nettype none
// front end: takes requests, drops ones that carry neither byte nor end mark
module sha256_front (
   sha256_req_if.sink           req,
   output logic                 push,
   output sha256_pkg::req_type  push_data,
   input  wire                  full
);
   assign req.ready = !full;
   assign push      = req.valid && !full &&
                      (req.payload.has_byte || req.payload.end_of_message);
   assign push_data = req.payload;
endmodule
`default_nettype wire

// File: design/sha256_core.sv
`default_nettype none
// back end: absorbs bytes, runs 64 rounds per block, pads, emits digest
module sha256_core (
   input  wire                  clock,
   input  wire                  reset,
   input  sha256_pkg::req_type  item,
   input  wire                  item_avail,
   output logic                 item_pop,
   sha256_rsp_if.source         rsp
);
   sha256_pkg::state_type state_ff, state_in;

   logic [5:0]  fill_ff, fill_in;
   logic [63:0] total_ff, total_in;
   sha256_pkg::word_type h_ff [8];
   sha256_pkg::word_type v_ff [8];
   sha256_pkg::word_type w_ff [16];
   logic [5:0]  round_ff, round_in;
   logic        final_ff, final_in;   // compression belongs to padding
   logic        padding_ff, padding_in; // 0x80 already placed
   logic        last_blk_ff, last_blk_in; // length block, emit afterwards
   logic [2:0]  widx_ff, widx_in;

   // control decoded combinationally
   logic start_blk, do_round, do_fold, absorb, pad_wr, h_reset;
   logic [7:0]  wr_byte;

   // message schedule word for this round
   sha256_pkg::word_type wt, s0, s1, w_new;
   always_comb begin
      s0 = sha256_pkg::rotr(w_ff[1], 7) ^ sha256_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = sha256_pkg::rotr(w_ff[14], 17) ^ sha256_pkg::rotr(w_ff[14], 19)
           ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      wt = w_ff[0];
   end

   sha256_pkg::word_type big0, big1, ch, maj, t1, t2;
   always_comb begin
      big1 = sha256_pkg::rotr(v_ff[4], 6) ^ sha256_pkg::rotr(v_ff[4], 11)
             ^ sha256_pkg::rotr(v_ff[4], 25);
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + big1 + ch + sha256_pkg::ROUND_K[round_ff] + wt;
      big0 = sha256_pkg::rotr(v_ff[0], 2) ^ sha256_pkg::rotr(v_ff[0], 13)
             ^ sha256_pkg::rotr(v_ff[0], 22);
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = big0 + maj;
   end

   logic [63:0] bit_len;
   assign bit_len = {total_ff[60:0], 3'b000};

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      total_in    = total_ff;
      round_in    = round_ff;
      final_in    = final_ff;
      padding_in  = padding_ff;
      last_blk_in = last_blk_ff;
      widx_in     = widx_ff;
      item_pop    = 1'b0;
      start_blk   = 1'b0;
      do_round    = 1'b0;
      do_fold     = 1'b0;
      absorb      = 1'b0;
      pad_wr      = 1'b0;
      h_reset     = 1'b0;
      wr_byte     = item.data_byte;
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (item_avail) begin
               if (item.has_byte && !final_ff) begin
                  // absorb byte; end mark handled on next visit
                  absorb   = 1'b1;
                  fill_in  = fill_ff + 6'd1;
                  total_in = total_ff + 64'd1;
                  final_in = item.end_of_message;
                  if (!item.end_of_message) item_pop = 1'b1;
                  if (fill_ff == 6'd63) begin
                     start_blk = 1'b1;
                     round_in  = '0;
                     state_in  = sha256_pkg::ST_ROUND;
                  end
               end else begin
                  final_in   = 1'b1;
                  padding_in = 1'b1;
                  state_in   = sha256_pkg::ST_PAD;
                  pad_wr     = 1'b1;
                  wr_byte    = sha256_pkg::PAD_BYTE;
                  fill_in    = fill_ff + 6'd1;
                  // 0x80 closes a full block
                  if (fill_ff == 6'd63) begin
                     start_blk = 1'b1;
                     round_in  = '0;
                     state_in  = sha256_pkg::ST_ROUND;
                  end
               end
            end
         end
         sha256_pkg::ST_PAD: begin
            pad_wr = 1'b1;
            if (fill_ff == '0 && !last_blk_ff && final_ff) begin
               // wrapped past a full padding block
               wr_byte = 8'h00;
            end
            if (fill_ff >= 6'(sha256_pkg::LEN_POS) && last_blk_ff) begin
               wr_byte = bit_len[6'(63 - 8 * (fill_ff - 6'(sha256_pkg::LEN_POS))) -: 8];
            end else begin
               wr_byte = 8'h00;
            end
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               start_blk = 1'b1;
               round_in  = '0;
               state_in  = sha256_pkg::ST_ROUND;
            end
         end
         sha256_pkg::ST_ROUND: begin
            do_round = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) state_in = sha256_pkg::ST_FOLD;
         end
         sha256_pkg::ST_FOLD: begin
            do_fold = 1'b1;
            if (!final_ff || !padding_ff) begin
               // more message bytes to absorb, or the last message byte filled the block: 0x80 still to place
               state_in = sha256_pkg::ST_IDLE;
            end else if (last_blk_ff) begin
               widx_in  = '0;
               state_in = sha256_pkg::ST_EMIT;
            end else begin
               state_in = sha256_pkg::ST_PAD;
            end
         end
         sha256_pkg::ST_EMIT: begin
            if (rsp.ready) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == 3'd7) begin
                  item_pop    = 1'b1;
                  h_reset     = 1'b1;
                  fill_in     = '0;
                  total_in    = '0;
                  final_in    = 1'b0;
                  padding_in  = 1'b0;
                  last_blk_in = 1'b0;
                  state_in    = sha256_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
      // padding target: this block carries the length if 0x80 fit before 56
      if (state_ff == sha256_pkg::ST_IDLE && item_avail && !(item.has_byte && !final_ff))
         last_blk_in = (fill_ff < 6'(sha256_pkg::LEN_POS));
      if (state_ff == sha256_pkg::ST_FOLD && final_ff && padding_ff && !last_blk_ff)
         last_blk_in = 1'b1;
   end

   assign rsp.valid               = (state_ff == sha256_pkg::ST_EMIT);
   assign rsp.payload.digest_word = h_ff[widx_ff];
   assign rsp.payload.word_index  = widx_ff;
   assign rsp.payload.last_word   = (widx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sha256_pkg::ST_IDLE;
         fill_ff     <= '0;
         total_ff    <= '0;
         round_ff    <= '0;
         final_ff    <= 1'b0;
         padding_ff  <= 1'b0;
         last_blk_ff <= 1'b0;
         widx_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         total_ff    <= total_in;
         round_ff    <= round_in;
         final_ff    <= final_in;
         padding_ff  <= padding_in;
         last_blk_ff <= last_blk_in;
         widx_ff     <= widx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || h_reset) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= sha256_pkg::INIT_H[i];
      end else if (do_fold) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end

   // block bytes shift into the schedule window, first byte ends up on top
   always_ff @(posedge clock) begin
      if (absorb || pad_wr) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= {w_ff[i][23:0], w_ff[i+1][31:24]};
         w_ff[15] <= {w_ff[15][23:0], wr_byte};
      end else if (do_round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
   end

   always_ff @(posedge clock) begin
      if (start_blk) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (do_round) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end
endmodule
`default_nettype wire

// File: design/sha256_message_digest_top.sv
`default_nettype none
// channel   direction  payload
// req_      in         data_byte[8], has_byte, end_of_message
// rsp_      out        digest_word[32], word_index[3], last_word
//
// A byte is absorbed into the schedule window; each full block runs 64 rounds
// plus a fold in the single round unit. End of message pads at one byte per
// cycle between compressions (up to two blocks), then emits eight words.
// Synchronous active-high reset. The request queue keeps taking requests, until
// it is full, while the core compresses or the digest waits on rsp_ready.
module sha256_message_digest_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire [7:0]   req_data_byte,
   input  wire         req_has_byte,
   input  wire         req_end_of_message,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   sha256_req_if req_ch ();
   sha256_rsp_if rsp_ch ();

   logic                push, full, pop, empty;
   sha256_pkg::req_type push_data, pop_data;

   assign req_ch.valid                  = req_valid;
   assign req_ch.payload.data_byte      = req_data_byte;
   assign req_ch.payload.has_byte       = req_has_byte;
   assign req_ch.payload.end_of_message = req_end_of_message;
   assign req_ready                     = req_ch.ready;

   assign rsp_valid       = rsp_ch.valid;
   assign rsp_ch.ready    = rsp_ready;
   assign rsp_digest_word = rsp_ch.payload.digest_word;
   assign rsp_word_index  = rsp_ch.payload.word_index;
   assign rsp_last_word   = rsp_ch.payload.last_word;

   sha256_front u_front (
      .req(req_ch.sink), .push, .push_data, .full);

   sha256_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock, .reset, .push, .push_data, .full, .pop, .pop_data, .empty);

   sha256_core u_core (
      .clock, .reset, .item(pop_data), .item_avail(!empty), .item_pop(pop),
      .rsp(rsp_ch.source));
endmodule
`default_nettype wire

// File: design/sha256_checker.sv
`default_nettype none
module sha256_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [2:0]  rsp_word_index,
   input wire        rsp_last_word,
   input wire [31:0] rsp_digest_word
);
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last_word mismatch");

   a_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest words out of order");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_digest_word)))
      else $error("stalled word changed");

   a_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> !rsp_valid)
      else $error("word after last");
endmodule

bind sha256_message_digest_top sha256_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_word_index, .rsp_last_word,
   .rsp_digest_word);
`default_nettype wire
